// File: sv/evf_pkg.sv
// ----------------------------------------------------------------------------
// Encoder velocity filter package
// Types, constants and helper functions shared by the velocity filter files.
// ----------------------------------------------------------------------------
package evf_pkg;

    localparam int LINES_PER_REV_DEF = 512;
    localparam int CHANNELS_DEF      = 2;

    // Widths of the data path.
    localparam int DIV_W  = 64;
    localparam int V_W    = 40;
    localparam int MINV_W = 27;
    localparam int THR_W  = 35;
    localparam int ADDR_W = 4;

    // Quarter turn (pi/2) times 1000 in Q20, two pi in Q16 and the low-pass scale.
    localparam logic [30:0] TICK_K    = 31'd1647099329;
    localparam logic [18:0] TWOPI_Q16 = 19'd411775;
    localparam logic [63:0] LPF_K     = 64'd100000;

    localparam logic signed [47:0] V_MAX48 = 48'sd549755813887;
    localparam logic signed [47:0] V_MIN48 = -48'sd549755813888;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_SPIKE  = 2'd1;
    localparam logic [1:0] REG_ZLOCK  = 2'd2;

    localparam logic [16:0] CUTOFF_RST = 17'd1500;
    localparam logic [15:0] SPIKE_RST  = 16'd768;
    localparam logic [4:0]  ZLOCK_RST  = 5'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_MINV,
        S_MINV_W,
        S_RAW,
        S_RAW_W,
        S_THR,
        S_MED,
        S_CLAMP,
        S_LOCK,
        S_W1,
        S_W2,
        S_BETA,
        S_BETA_W,
        S_STEP,
        S_STORE,
        S_OUT
    } t_state;

    function automatic logic signed [V_W-1:0] sat_v(input logic signed [47:0] v);
        logic signed [V_W-1:0] r;
        if (v > V_MAX48) begin
            r = V_MAX48[V_W-1:0];
        end else if (v < V_MIN48) begin
            r = V_MIN48[V_W-1:0];
        end else begin
            r = v[V_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [V_W:0] abs_v(input logic signed [V_W:0] v);
        return v[V_W] ? (~v + 1'b1) : v;
    endfunction

endpackage

// File: sv/evf_if.sv
// ----------------------------------------------------------------------------
// Encoder velocity filter channels
// Valid/ready interfaces for the sample words and the result words.
// ----------------------------------------------------------------------------
interface evf_in_if;
    logic               valid;
    logic               ready;
    logic               channel;
    logic signed [15:0] count_delta;
    logic        [15:0] elapsed_ms;

    modport source (output valid, channel, count_delta, elapsed_ms, input ready);
    modport sink   (input valid, channel, count_delta, elapsed_ms, output ready);
endinterface

interface evf_out_if;
    logic               valid;
    logic               ready;
    logic               result_channel;
    logic signed [39:0] velocity_q16;
    logic signed [31:0] position_count;
    logic               zero_locked;

    modport source (output valid, result_channel, velocity_q16, position_count,
                    zero_locked, input ready);
    modport sink   (input valid, result_channel, velocity_q16, position_count,
                    zero_locked, output ready);
endinterface

// File: sv/evf_div.sv
// ----------------------------------------------------------------------------
// Encoder velocity filter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module evf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [evf_pkg::DIV_W-1:0]  i_dividend,
    input  logic [evf_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [evf_pkg::DIV_W-1:0]  o_quotient
);
    localparam int CNT_W = $clog2(evf_pkg::DIV_W + 1);

    logic [evf_pkg::DIV_W-1:0] r_rem;
    logic [evf_pkg::DIV_W-1:0] r_quo;
    logic [evf_pkg::DIV_W-1:0] r_dsr;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [evf_pkg::DIV_W:0]   rem_sh;
    logic [evf_pkg::DIV_W:0]   rem_sub;
    logic                      fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[evf_pkg::DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dsr};
        fits    = (rem_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(evf_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[evf_pkg::DIV_W-1:0] : rem_sh[evf_pkg::DIV_W-1:0];
            r_quo <= {r_quo[evf_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: sv/encoder_velocity_filter.sv
// ----------------------------------------------------------------------------
// Encoder velocity filter
// Per-channel position, median, spike clamp, zero lock and low-pass filter.
// ----------------------------------------------------------------------------
// Each sample word takes one channel through a sequencer around a shared
// bit-serial divider. A word with zero elapsed time only adds to the
// position. Otherwise the divider runs twice (minimum velocity and raw
// velocity); a word whose clamped median falls below the minimum velocity,
// or that loads the filter, goes to the output after that. A word that runs
// the low-pass filter needs a third division, for beta.
// The input is not ready while a word is in work; a finished result waits in
// the output register while the next word is taken, but that word holds in
// S_OUT until the register is free.
module encoder_velocity_filter #(
    parameter int LINES_PER_REV = evf_pkg::LINES_PER_REV_DEF,
    parameter int CHANNELS      = evf_pkg::CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [evf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    evf_in_if.sink                     i_in,
    evf_out_if.source                  o_out
);
    localparam int V_W  = evf_pkg::V_W;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam longint unsigned DEN_MAX = 64'(LINES_PER_REV) * 64'd16 * 64'd65535;
    localparam int DEN_W = $clog2(DEN_MAX + 1);
    localparam logic [DEN_W-1:0] LPR16 = DEN_W'(64'(LINES_PER_REV) * 64'd16);

    // Configuration registers.
    logic [16:0] r_cutoff;
    logic [15:0] r_spike;
    logic [4:0]  r_zlc;

    // Per-channel state.
    logic        [31:0]    r_pos_tot [CHANNELS];
    logic        [31:0]    r_pos_smp [CHANNELS];
    logic signed [V_W-1:0] r_win     [CHANNELS][3];
    logic        [1:0]     r_wptr    [CHANNELS];
    logic signed [V_W-1:0] r_filt    [CHANNELS];
    logic                  r_started [CHANNELS];
    logic        [4:0]     r_run     [CHANNELS];

    // Working registers of the current word.
    evf_pkg::t_state       r_state, n_state;
    logic                  r_chin;
    logic [CH_W-1:0]       r_ch;
    logic signed [15:0]    r_delta;
    logic [15:0]           r_dt;
    logic                  r_neg;
    logic [31:0]           r_mag;
    logic [DEN_W-1:0]      r_den;
    logic [62:0]           r_mk;
    logic [evf_pkg::MINV_W-1:0] r_minv;
    logic signed [V_W-1:0] r_raw;
    logic [evf_pkg::THR_W-1:0]  r_thr;
    logic signed [V_W-1:0] r_med;
    logic                  r_locked;
    logic [32:0]           r_wprod;
    logic [51:0]           r_w;
    logic [22:0]           r_beta;
    logic [41:0]           r_stepmag;
    logic                  r_eneg;

    // Output register.
    logic                  r_ovalid;
    logic                  r_ochan;
    logic signed [V_W-1:0] r_ovel;
    logic signed [31:0]    r_opos;
    logic                  r_olock;

    // Divider hookup.
    logic                       div_start;
    logic [evf_pkg::DIV_W-1:0]  div_dividend;
    logic [evf_pkg::DIV_W-1:0]  div_divisor;
    logic                       div_done;
    logic [evf_pkg::DIV_W-1:0]  div_quo;

    // Combinational helpers.
    logic                  accept;
    logic                  out_free;
    logic                  cfg_wr;
    logic [31:0]           pos_new;
    logic [31:0]           pos_diff;
    logic [V_W-1:0]        raw_sat;
    logic [V_W:0]          raw_abs;
    logic [42:0]           thr_prod;
    logic signed [V_W-1:0] win_n [3];
    logic signed [V_W-1:0] med3;
    logic signed [V_W-1:0] prev;
    logic signed [V_W:0]   diff;
    logic [V_W:0]          diff_abs;
    logic signed [47:0]    clamp_sum;
    logic [V_W:0]          med_abs;
    logic                  small_med;
    logic [4:0]            run_n;
    logic                  lock_fire;
    logic [22:0]           alpha;
    logic signed [V_W:0]   err;
    logic [V_W:0]          err_abs;
    logic [63:0]           step_prod;
    logic signed [47:0]    filt_sum;

    function automatic logic signed [V_W-1:0] mid3(input logic signed [V_W-1:0] a,
                                                   input logic signed [V_W-1:0] b,
                                                   input logic signed [V_W-1:0] c);
        logic signed [V_W-1:0] lo;
        logic signed [V_W-1:0] hi;
        logic signed [V_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    evf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign cfg_wr   = psel && penable && pwrite;

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= evf_pkg::CUTOFF_RST;
            r_spike  <= evf_pkg::SPIKE_RST;
            r_zlc    <= evf_pkg::ZLOCK_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                evf_pkg::REG_CUTOFF: r_cutoff <= pwdata[16:0];
                evf_pkg::REG_SPIKE:  r_spike  <= pwdata[15:0];
                evf_pkg::REG_ZLOCK:  r_zlc    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            evf_pkg::REG_CUTOFF: prdata = 32'(r_cutoff);
            evf_pkg::REG_SPIKE:  prdata = 32'(r_spike);
            evf_pkg::REG_ZLOCK:  prdata = 32'(r_zlc);
            default:             prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Data path helpers.
    always_comb begin
        pos_new  = r_pos_tot[r_ch] + 32'(r_delta);
        pos_diff = pos_new - r_pos_smp[r_ch];

        // Raw velocity, saturated to the output range.
        if (r_neg) begin
            raw_sat = (div_quo > 64'h80_0000_0000) ? V_W'(evf_pkg::V_MIN48)
                                                   : (~div_quo[V_W-1:0] + 1'b1);
        end else begin
            raw_sat = (div_quo > 64'h7F_FFFF_FFFF) ? V_W'(evf_pkg::V_MAX48)
                                                   : div_quo[V_W-1:0];
        end
        raw_abs  = evf_pkg::abs_v((V_W+1)'(r_raw));
        thr_prod = 43'(r_spike) * 43'(r_minv);

        // Median over the window with the new value written in.
        for (int k = 0; k < 3; k++) begin
            win_n[k] = (r_wptr[r_ch] == 2'(k) || (r_wptr[r_ch] > 2'd2 && k == 0))
                       ? r_raw : r_win[r_ch][k];
        end
        med3 = mid3(win_n[0], win_n[1], win_n[2]);

        // Spike clamp against the last filtered value.
        prev      = r_started[r_ch] ? r_filt[r_ch] : r_med;
        diff      = (V_W+1)'(r_med) - (V_W+1)'(prev);
        diff_abs  = evf_pkg::abs_v(diff);
        clamp_sum = diff[V_W] ? (48'(prev) - 48'(r_thr)) : (48'(prev) + 48'(r_thr));

        // Zero lock.
        med_abs   = evf_pkg::abs_v((V_W+1)'(r_med));
        small_med = (med_abs < (V_W+1)'(r_minv));
        run_n     = (r_run[r_ch] < 5'd31) ? r_run[r_ch] + 5'd1 : r_run[r_ch];
        lock_fire = (run_n >= r_zlc);

        // Low-pass step.
        alpha     = 23'h40_0000 - r_beta;
        err       = (V_W+1)'(r_med) - (V_W+1)'(r_filt[r_ch]);
        err_abs   = evf_pkg::abs_v(err);
        step_prod = 64'(err_abs) * 64'(alpha);
        filt_sum  = r_eneg ? (48'(r_filt[r_ch]) - 48'(r_stepmag))
                           : (48'(r_filt[r_ch]) + 48'(r_stepmag));
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= evf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = 64'(r_mk);
        div_divisor  = 64'(r_den);
        unique case (r_state)
            evf_pkg::S_IDLE:   if (accept) n_state = evf_pkg::S_LOAD;
            evf_pkg::S_LOAD:   n_state = (r_dt == 16'd0) ? evf_pkg::S_OUT : evf_pkg::S_PREP;
            evf_pkg::S_PREP:   n_state = evf_pkg::S_MINV;
            evf_pkg::S_MINV: begin
                div_start    = 1'b1;
                div_dividend = 64'(evf_pkg::TICK_K);
                n_state      = evf_pkg::S_MINV_W;
            end
            evf_pkg::S_MINV_W: if (div_done) n_state = evf_pkg::S_RAW;
            evf_pkg::S_RAW: begin
                div_start = 1'b1;
                n_state   = evf_pkg::S_RAW_W;
            end
            evf_pkg::S_RAW_W:  if (div_done) n_state = evf_pkg::S_THR;
            evf_pkg::S_THR:    n_state = evf_pkg::S_MED;
            evf_pkg::S_MED:    n_state = evf_pkg::S_CLAMP;
            evf_pkg::S_CLAMP:  n_state = evf_pkg::S_LOCK;
            evf_pkg::S_LOCK: begin
                if (small_med || !r_started[r_ch]) begin
                    n_state = evf_pkg::S_OUT;
                end else begin
                    n_state = evf_pkg::S_W1;
                end
            end
            evf_pkg::S_W1:     n_state = evf_pkg::S_W2;
            evf_pkg::S_W2:     n_state = evf_pkg::S_BETA;
            evf_pkg::S_BETA: begin
                div_start    = 1'b1;
                div_dividend = evf_pkg::LPF_K << 38;
                div_divisor  = (evf_pkg::LPF_K << 16) + 64'(r_w);
                n_state      = evf_pkg::S_BETA_W;
            end
            evf_pkg::S_BETA_W: if (div_done) n_state = evf_pkg::S_STEP;
            evf_pkg::S_STEP:   n_state = evf_pkg::S_STORE;
            evf_pkg::S_STORE:  n_state = evf_pkg::S_OUT;
            evf_pkg::S_OUT:    if (out_free) n_state = evf_pkg::S_IDLE;
            default:           n_state = evf_pkg::S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == evf_pkg::S_IDLE);

    // Working registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            evf_pkg::S_IDLE: begin
                if (accept) begin
                    r_chin  <= i_in.channel;
                    r_ch    <= (CHANNELS > 1) ? CH_W'(i_in.channel) : '0;
                    r_delta <= i_in.count_delta;
                    r_dt    <= i_in.elapsed_ms;
                end
            end
            evf_pkg::S_LOAD: begin
                r_locked <= 1'b0;
                r_neg    <= pos_diff[31];
                r_mag    <= pos_diff[31] ? (~pos_diff + 32'd1) : pos_diff;
            end
            evf_pkg::S_PREP: begin
                r_den <= DEN_W'(r_dt) * LPR16;
                r_mk  <= 63'(r_mag) * 63'(evf_pkg::TICK_K);
            end
            evf_pkg::S_MINV_W: if (div_done) r_minv <= div_quo[evf_pkg::MINV_W-1:0];
            evf_pkg::S_RAW_W:  if (div_done) r_raw <= raw_sat;
            evf_pkg::S_THR: begin
                r_thr <= thr_prod[42:8];
                // Values below the resolution read as standstill.
                if (raw_abs < (V_W+1)'(r_minv)) r_raw <= '0;
            end
            evf_pkg::S_MED: r_med <= med3;
            evf_pkg::S_CLAMP: begin
                if (diff_abs > (V_W+1)'(r_thr)) r_med <= evf_pkg::sat_v(clamp_sum);
            end
            evf_pkg::S_LOCK: begin
                if (small_med && lock_fire) r_locked <= 1'b1;
            end
            evf_pkg::S_W1:     r_wprod <= 33'(r_dt) * 33'(r_cutoff);
            evf_pkg::S_W2:     r_w <= 52'(r_wprod) * 52'(evf_pkg::TWOPI_Q16);
            evf_pkg::S_BETA_W: if (div_done) r_beta <= div_quo[22:0];
            evf_pkg::S_STEP: begin
                r_stepmag <= step_prod[63:22];
                r_eneg    <= err[V_W];
            end
            default: ;
        endcase
    end

    // Channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos_tot[c] <= '0;
                r_pos_smp[c] <= '0;
                r_wptr[c]    <= '0;
                r_filt[c]    <= '0;
                r_started[c] <= 1'b0;
                r_run[c]     <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_win[c][k] <= '0;
                end
            end
        end else begin
            unique case (r_state)
                evf_pkg::S_LOAD: begin
                    r_pos_tot[r_ch] <= pos_new;
                    if (r_dt != 16'd0) r_pos_smp[r_ch] <= pos_new;
                end
                evf_pkg::S_MED: begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[r_ch][k] <= win_n[k];
                    end
                    r_wptr[r_ch] <= (r_wptr[r_ch] == 2'd2 || r_wptr[r_ch] > 2'd2)
                                    ? 2'd0 : r_wptr[r_ch] + 2'd1;
                end
                evf_pkg::S_LOCK: begin
                    if (small_med) begin
                        r_run[r_ch] <= run_n;
                        if (lock_fire) begin
                            r_filt[r_ch]    <= '0;
                            r_started[r_ch] <= 1'b1;
                        end
                    end else begin
                        r_run[r_ch] <= '0;
                        if (!r_started[r_ch]) begin
                            r_filt[r_ch]    <= r_med;
                            r_started[r_ch] <= 1'b1;
                        end
                    end
                end
                evf_pkg::S_STORE: r_filt[r_ch] <= evf_pkg::sat_v(filt_sum);
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == evf_pkg::S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == evf_pkg::S_OUT && out_free) begin
            r_ochan <= r_chin;
            r_ovel  <= r_filt[r_ch];
            r_opos  <= r_pos_tot[r_ch];
            r_olock <= r_locked;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.result_channel = r_ochan;
    assign o_out.velocity_q16   = r_ovel;
    assign o_out.position_count = r_opos;
    assign o_out.zero_locked    = r_olock;
endmodule

// File: sv/evf_checker.sv
// ----------------------------------------------------------------------------
// Encoder velocity filter checker
// Port-level checks on the sample and result words, bound to the top level.
// ----------------------------------------------------------------------------
module evf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [39:0] i_out_velocity,
    input logic               i_out_locked
);
    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_velocity))
        else $error("result word changed while stalled");

    // A locked result always reports standstill.
    a_lock_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_locked |-> i_out_velocity == 40'sd0)
        else $error("zero lock with nonzero velocity");

    // The block works on one word at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted word");

    // A result never appears the cycle after a word is taken.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result word too early");
endmodule

bind encoder_velocity_filter evf_checker u_evf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_velocity (o_out.velocity_q16),
    .i_out_locked   (o_out.zero_locked)
);

// File: tb/sv/tb_encoder_velocity_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder velocity filter testbench
// Drives sample words with random gaps and result stalls, writes the
// configuration registers between phases, and compares every result word
// with a bench velocity predictor or, for typed rows, with the typed result.
// ----------------------------------------------------------------------------
module tb_encoder_velocity_filter;

    localparam int                IDLE_LIMIT   = 20000;
    localparam int                RANDOM_WORDS = 1030;
    localparam longint unsigned   TICK_ANGLE_K = 64'd1647099329;
    localparam longint unsigned   TWO_PI_Q16   = 64'd411775;
    localparam longint unsigned   LOWPASS_K    = 64'd100000;
    localparam longint            VEL_HI       = 64'sd549755813887;
    localparam longint            VEL_LO       = -64'sd549755813888;

    typedef struct packed {
        logic               ch;
        logic signed [39:0] vel;
        logic signed [31:0] pos;
        logic               lock;
    } t_vel_word;

    typedef struct packed {
        logic               ch;
        logic signed [15:0] delta;
        logic        [15:0] dt;
        logic               typed;
        logic signed [39:0] vel;
        logic signed [31:0] pos;
        logic               lock;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [evf_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    evf_in_if  in_if();
    evf_out_if out_if();

    encoder_velocity_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state, one entry per channel.
    logic [31:0] pos_total   [2];
    logic [31:0] pos_sampled [2];
    longint      median_buf  [2][3];
    int          median_ptr  [2];
    longint      vel_filt    [2];
    logic        filt_valid  [2];
    int          small_run   [2];
    longint unsigned cutoff_reg, spike_reg, zlock_reg;

    t_vel_word vel_exp_q[$];
    int        mismatches  = 0;
    int        words_in    = 0;
    int        idle_cycles = 0;
    int        speed [2];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint sat40(longint v);
        if (v > VEL_HI) return VEL_HI;
        if (v < VEL_LO) return VEL_LO;
        return v;
    endfunction

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint middle_of(longint a, longint b, longint c);
        longint lo, hi, m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    function automatic t_vel_word predict_velocity(logic ch, logic signed [15:0] delta,
                                                   logic [15:0] dt);
        longint unsigned den, m, w, beta, alpha, mag;
        longint          min_v, raw, med, prev, diff, thr, e, step;
        logic [31:0]     d;
        logic            neg;
        logic            locked;
        t_vel_word       r;
        locked = 1'b0;
        pos_total[ch] = pos_total[ch] + {{16{delta[15]}}, delta};
        if (dt != 0) begin
            den   = longint'(dt) * 512 * 16;
            d     = pos_total[ch] - pos_sampled[ch];
            neg   = d[31];
            m     = neg ? {32'b0, 32'(-d)} : {32'b0, d};
            min_v = longint'(TICK_ANGLE_K / den);
            raw   = longint'((m * TICK_ANGLE_K) / den);
            if (neg) raw = -raw;
            raw = sat40(raw);
            if (mag_of(raw) < min_v) raw = 0;
            median_buf[ch][median_ptr[ch]] = raw;
            median_ptr[ch] = (median_ptr[ch] == 2) ? 0 : median_ptr[ch] + 1;
            med  = middle_of(median_buf[ch][0], median_buf[ch][1], median_buf[ch][2]);
            prev = filt_valid[ch] ? vel_filt[ch] : med;
            diff = med - prev;
            thr  = longint'((spike_reg * longint'(min_v)) >> 8);
            if (mag_of(diff) > thr) begin
                med = (diff > 0) ? sat40(prev + thr) : sat40(prev - thr);
            end
            if (mag_of(med) < min_v) begin
                if (small_run[ch] < 31) small_run[ch]++;
                if (small_run[ch] >= zlock_reg) begin
                    vel_filt[ch]   = 0;
                    filt_valid[ch] = 1'b1;
                    locked         = 1'b1;
                end
            end else begin
                small_run[ch] = 0;
                if (!filt_valid[ch]) begin
                    vel_filt[ch]   = med;
                    filt_valid[ch] = 1'b1;
                end else begin
                    w     = longint'(dt) * cutoff_reg * TWO_PI_Q16;
                    beta  = (LOWPASS_K << 38) / ((LOWPASS_K << 16) + w);
                    alpha = (64'd1 << 22) - beta;
                    e     = med - vel_filt[ch];
                    mag   = mag_of(e);
                    step  = longint'((mag * alpha) >> 22);
                    if (e < 0) step = -step;
                    vel_filt[ch] = sat40(vel_filt[ch] + step);
                end
            end
            pos_sampled[ch] = pos_total[ch];
        end
        r.ch   = ch;
        r.vel  = vel_filt[ch][39:0];
        r.pos  = pos_total[ch];
        r.lock = locked;
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= evf_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            evf_pkg::REG_CUTOFF: cutoff_reg = value & 32'h1FFFF;
            evf_pkg::REG_SPIKE:  spike_reg  = value & 32'hFFFF;
            evf_pkg::REG_ZLOCK:  zlock_reg  = value & 32'h1F;
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] cutoff, logic [31:0] spike, logic [31:0] zlock);
        // Withdraw the last word first so the block does not take it again.
        in_if.valid <= 1'b0;
        while (vel_exp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        write_reg(evf_pkg::REG_CUTOFF, cutoff);
        write_reg(evf_pkg::REG_SPIKE, spike);
        write_reg(evf_pkg::REG_ZLOCK, zlock);
    endtask

    // Offers one word after an optional gap; returns once it is accepted.
    task automatic send_word(logic ch, logic signed [15:0] delta, logic [15:0] dt,
                             bit no_gaps, bit typed, t_vel_word typed_word);
        int        gap;
        int        pick;
        t_vel_word w;
        pick = $urandom_range(99);
        if (no_gaps || pick < 60) gap = 0;
        else if (pick < 95) gap = $urandom_range(5, 1);
        else gap = $urandom_range(300, 20);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.channel     <= ch;
        in_if.count_delta <= delta;
        in_if.elapsed_ms  <= dt;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        w = predict_velocity(ch, delta, dt);
        if (typed) w = typed_word;
        vel_exp_q.push_back(w);
        words_in++;
    endtask

    // Result side: random stalls, and one long hold-off that backs up the block.
    initial begin
        int  n, pick;
        bit  held;
        held = 1'b0;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && words_in >= 400) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 50) begin
                out_if.ready <= 1'b1;
                n = $urandom_range(40, 1);
            end else if (pick < 90) begin
                out_if.ready <= 1'b0;
                n = $urandom_range(4, 1);
            end else begin
                out_if.ready <= 1'b0;
                n = $urandom_range(150, 20);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_vel_word w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (vel_exp_q.size() == 0) begin
                $error("result word with nothing expected: ch %0d vel %0d pos %0d",
                       out_if.result_channel, out_if.velocity_q16, out_if.position_count);
                mismatches++;
            end else begin
                w = vel_exp_q.pop_front();
                if (out_if.result_channel !== w.ch) begin
                    $error("result_channel: expected %0d, got %0d", w.ch,
                           out_if.result_channel);
                    mismatches++;
                end
                if (out_if.velocity_q16 !== w.vel) begin
                    $error("velocity_q16: expected %0d, got %0d", w.vel,
                           out_if.velocity_q16);
                    mismatches++;
                end
                if (out_if.position_count !== w.pos) begin
                    $error("position_count: expected %0d, got %0d", w.pos,
                           out_if.position_count);
                    mismatches++;
                end
                if (out_if.zero_locked !== w.lock) begin
                    $error("zero_locked: expected %0d, got %0d", w.lock,
                           out_if.zero_locked);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_stim_row   rows[$];
        logic [31:0] phase_cfg[6][3];
        logic        ch;
        logic signed [15:0] delta;
        logic [15:0] dt;
        int          pick, v, per_phase;
        t_vel_word   tw;

        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.channel     = 1'b0;
        in_if.count_delta = '0;
        in_if.elapsed_ms  = '0;
        for (int c = 0; c < 2; c++) begin
            pos_total[c]   = '0;
            pos_sampled[c] = '0;
            median_buf[c]  = '{0, 0, 0};
            median_ptr[c]  = 0;
            vel_filt[c]    = 0;
            filt_valid[c]  = 1'b0;
            small_run[c]   = 0;
            speed[c]       = 0;
        end
        cutoff_reg = evf_pkg::CUTOFF_RST;
        spike_reg  = evf_pkg::SPIKE_RST;
        zlock_reg  = evf_pkg::ZLOCK_RST;

        // Rows with typed results are the plain position updates right after reset.
        rows = '{
            '{1'b0, 16'sd0,      16'd0,     1'b1, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd32767,  16'd0,     1'b1, 40'sd0, 32'sd32767,  1'b0},
            '{1'b1, -16'sd32768, 16'd0,     1'b1, 40'sd0, -32'sd32768, 1'b0},
            '{1'b0, 16'sd0,      16'd1,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd100,    16'd1,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd100,    16'd65535, 1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b1, -16'sd32768, 16'd1,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b1, 16'sd32767,  16'd1,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b1, 16'sd0,      16'd5,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b1, 16'sd0,      16'd5,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b1, 16'sd0,      16'd5,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b1, 16'sd0,      16'd5,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd1,      16'd65535, 1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd0,      16'd10,    1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd0,      16'd10,    1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd500,    16'd2,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd500,    16'd2,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, -16'sd500,   16'd2,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b0, 16'sd32767,  16'd2,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b1, -16'sd1,     16'd0,     1'b0, 40'sd0, 32'sd0,      1'b0},
            '{1'b1, -16'sd1,     16'd65535, 1'b0, 40'sd0, 32'sd0,      1'b0}
        };

        phase_cfg = '{
            '{32'd1500,   32'd768,   32'd2},
            '{32'd0,      32'd1,     32'd0},
            '{32'd11,     32'd65535, 32'd1},
            '{32'd100000, 32'd256,   32'd20},
            '{32'd131071, 32'd0,     32'd31},
            '{32'd1500,   32'd768,   32'd2}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            tw = '{rows[i].ch, rows[i].vel, rows[i].pos, rows[i].lock};
            send_word(rows[i].ch, rows[i].delta, rows[i].dt, 1'b0, rows[i].typed, tw);
        end

        per_phase = RANDOM_WORDS / 6;
        for (int ph = 0; ph < 6; ph++) begin
            configure(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
            for (int k = 0; k < per_phase; k++) begin
                ch   = 1'($urandom_range(1));
                pick = $urandom_range(99);
                if (pick < 75) begin
                    // Steady motion with occasional speed jumps and standstill runs.
                    if ($urandom_range(99) < 10) begin
                        speed[ch] = ($urandom_range(3) == 0) ? 0
                                    : int'($urandom_range(6000)) - 3000;
                    end
                    dt = 16'($urandom_range(10, 1));
                    if ($urandom_range(19) == 0) dt = 16'd0;
                    v = speed[ch] * ((dt == 0) ? 1 : int'(dt))
                        + int'($urandom_range(20)) - 10;
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                    delta = 16'(v);
                end else begin
                    delta = 16'($urandom);
                    dt = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(200));
                end
                send_word(ch, delta, dt, ph[0], 1'b0, '0);
            end
        end

        in_if.valid <= 1'b0;
        while (vel_exp_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
